>>> rtl/assert_macros.svh
// Assertion macros for the convolution RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds whenever ante holds, outside reset.
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/c2d_pkg.sv
// Shared types, codes and helpers for the convolution block.
package c2d_pkg;

  localparam int MAX_COLUMNS_DEF      = 64;
  localparam int MAX_KERNEL_ROWS_DEF  = 5;
  localparam int MAX_KERNEL_COLS_DEF  = 5;
  localparam int MAX_IN_CHANNELS_DEF  = 16;
  localparam int MAX_OUT_CHANNELS_DEF = 8;
  localparam int MAX_IMAGE_ROWS       = 1024;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_BIAS   = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_KROWS  = 3'd2,
    REG_KCOLS  = 3'd3,
    REG_IN_CH  = 3'd4,
    REG_OUT_CH = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         tap_row;
    logic [2:0]         tap_column;
    logic [3:0]         in_channel_sel;
    logic [2:0]         out_channel_sel;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_row;
    logic [5:0]         out_column;
    logic [2:0]         out_channel;
    logic signed [47:0] sum;
    logic               last_of_run;
  } out_item_t;

  // Control that travels down the cell chain with each tap.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tok_ctl_t;

  // Saturate a 32-bit value to signed 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/c2d_cell.sv
// One MAC cell: weights and accumulator for one output channel.
module c2d_cell #(
  parameter int TAPS = c2d_pkg::MAX_KERNEL_ROWS_DEF * c2d_pkg::MAX_KERNEL_COLS_DEF
                       * c2d_pkg::MAX_IN_CHANNELS_DEF,
  parameter int TW   = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  c2d_pkg::tok_ctl_t   in_ctl,
  input  logic [TW-1:0]       in_tap,
  input  logic signed [15:0]  in_sample,
  input  logic                wr_en,
  input  logic [TW-1:0]       wr_tap,
  input  logic signed [15:0]  wr_data,
  input  logic                bias_en,
  input  logic signed [31:0]  bias_data,
  output c2d_pkg::tok_ctl_t   out_ctl,
  output logic [TW-1:0]       out_tap,
  output logic signed [15:0]  out_sample,
  output logic signed [47:0]  acc,
  output logic                done
);

  logic signed [15:0] wmem [TAPS];
  logic signed [15:0] w_q;
  c2d_pkg::tok_ctl_t  a_ctl;
  logic [TW-1:0]      a_tap;
  logic signed [15:0] a_sample;
  c2d_pkg::tok_ctl_t  b_ctl;
  logic signed [31:0] prod;
  logic signed [31:0] bias;

  // Weight memory: one write port, one registered read at the incoming tap.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[wr_tap] <= wr_data;
    end
    w_q <= wmem[in_tap];
  end

  // Register the neighbor's control and hand it on; b_ctl follows it to the accumulator, and done marks the last tap.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
      done  <= 1'b0;
    end else begin
      a_ctl <= in_ctl;
      b_ctl <= a_ctl;
      done  <= b_ctl.vld & b_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    a_tap    <= in_tap;
    a_sample <= in_sample;
    prod     <= w_q * a_sample;
    if (bias_en) begin
      bias <= bias_data;
    end
    // Start from the bias on the first tap, then accumulate.
    if (b_ctl.vld) begin
      if (b_ctl.first) begin
        acc <= 48'(bias) + 48'(prod);
      end else begin
        acc <= acc + 48'(prod);
      end
    end
  end

  assign out_ctl    = a_ctl;
  assign out_tap    = a_tap;
  assign out_sample = a_sample;

endmodule

>>> rtl/conv2d_multichannel_forward_unit.sv
// Top level: config port, line store, tap sequencer, MAC cell chain, output.
// Weight, bias and samples that finish no window do not stall the input.
// A sample that finishes a window issues its KR*KC*IC taps through the line store
// read port, passes them down the cell chain, then loads one result per output channel.
// No new item is accepted until that sample's last result is loaded.
// Synchronous reset clears counters and control; memories are undefined until written.
`include "assert_macros.svh"
module conv2d_multichannel_forward_unit #(
  parameter int MAX_COLUMNS      = c2d_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_KERNEL_ROWS  = c2d_pkg::MAX_KERNEL_ROWS_DEF,
  parameter int MAX_KERNEL_COLS  = c2d_pkg::MAX_KERNEL_COLS_DEF,
  parameter int MAX_IN_CHANNELS  = c2d_pkg::MAX_IN_CHANNELS_DEF,
  parameter int MAX_OUT_CHANNELS = c2d_pkg::MAX_OUT_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  c2d_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output c2d_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SW    = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ICW   = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int OCW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int KRW   = $clog2(MAX_KERNEL_ROWS + 1);
  localparam int KCW   = $clog2(MAX_KERNEL_COLS + 1);
  localparam int ICNW  = $clog2(MAX_IN_CHANNELS + 1);
  localparam int OCNW  = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int COLSW = $clog2(MAX_COLUMNS + 1);
  localparam int LDEP  = MAX_KERNEL_ROWS * MAX_COLUMNS * MAX_IN_CHANNELS;
  localparam int LW    = (LDEP > 1) ? $clog2(LDEP) : 1;
  localparam int TAPS  = MAX_KERNEL_ROWS * MAX_KERNEL_COLS * MAX_IN_CHANNELS;
  localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [LW-1:0] ROW_STRIDE = LW'(MAX_COLUMNS * MAX_IN_CHANNELS);
  localparam logic [LW-1:0] COL_STRIDE = LW'(MAX_IN_CHANNELS);
  localparam logic [TW-1:0] KROW_STRIDE = TW'(MAX_KERNEL_COLS * MAX_IN_CHANNELS);
  localparam logic [TW-1:0] KCOL_STRIDE = TW'(MAX_IN_CHANNELS);

  // Configuration registers.
  logic [10:0] cfg_rows;
  logic [6:0]  cfg_cols;
  logic [2:0]  cfg_krows;
  logic [2:0]  cfg_kcols;
  logic [4:0]  cfg_in_ch;
  logic [3:0]  cfg_out_ch;
  logic        cfg_wr;
  logic        cfg_hit;

  // Clamped values in use.
  logic [10:0]      rows_c;
  logic [COLSW-1:0] cols_c;
  logic [KRW-1:0]   kr_c;
  logic [KCW-1:0]   kc_c;
  logic [ICNW-1:0]  icn_c;
  logic [OCNW-1:0]  ocn_c;

  // Position counters.
  logic [9:0]     row_cnt;
  logic [SW-1:0]  slot_cnt;
  logic [CW-1:0]  col_cnt;
  logic [ICW-1:0] ch_cnt;

  c2d_pkg::state_t state, state_next;

  // Sequencer registers.
  logic [KRW-1:0]  m_idx;
  logic [KCW-1:0]  n_idx;
  logic [ICW-1:0]  ic_idx;
  logic [SW-1:0]   rd_slot;
  logic [9:0]      win_row;
  logic [CW-1:0]   win_col;
  logic [OCW-1:0]  oc_idx;

  logic signed [15:0] lines [LDEP];
  logic signed [15:0] rd_sample;
  logic [LW-1:0]      rd_addr;
  logic [LW-1:0]      wr_addr;
  logic [TW-1:0]      iss_tap_c;
  logic [TW-1:0]      iss_tap;
  c2d_pkg::tok_ctl_t  iss_ctl_c;
  c2d_pkg::tok_ctl_t  iss_ctl;

  logic in_acc;
  logic is_sample;
  logic fire;
  logic ic_last, n_last, m_last;
  logic out_load;
  logic oc_last;
  logic [TW-1:0]      wt_tap;
  logic               wt_ok;
  logic [SW:0]        slot_sum;

  c2d_pkg::tok_ctl_t  ch_ctl    [MAX_OUT_CHANNELS+1];
  logic [TW-1:0]      ch_tap    [MAX_OUT_CHANNELS+1];
  logic signed [15:0] ch_sample [MAX_OUT_CHANNELS+1];
  logic signed [47:0] cell_acc  [MAX_OUT_CHANNELS];
  logic [MAX_OUT_CHANNELS-1:0] cell_done;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign in_stall = (state != c2d_pkg::S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign is_sample = (in_item.req_type == c2d_pkg::REQ_SAMPLE);

  // Decode register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rows   <= 11'd8;
      cfg_cols   <= 7'd8;
      cfg_krows  <= 3'd3;
      cfg_kcols  <= 3'd3;
      cfg_in_ch  <= 5'd1;
      cfg_out_ch <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        c2d_pkg::REG_ROWS:   cfg_rows   <= pwdata[10:0];
        c2d_pkg::REG_COLS:   cfg_cols   <= pwdata[6:0];
        c2d_pkg::REG_KROWS:  cfg_krows  <= pwdata[2:0];
        c2d_pkg::REG_KCOLS:  cfg_kcols  <= pwdata[2:0];
        c2d_pkg::REG_IN_CH:  cfg_in_ch  <= pwdata[4:0];
        c2d_pkg::REG_OUT_CH: cfg_out_ch <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    prdata  = '0;
    unique case (paddr[4:2])
      c2d_pkg::REG_ROWS:   begin prdata = 32'(cfg_rows);   cfg_hit = 1'b1; end
      c2d_pkg::REG_COLS:   begin prdata = 32'(cfg_cols);   cfg_hit = 1'b1; end
      c2d_pkg::REG_KROWS:  begin prdata = 32'(cfg_krows);  cfg_hit = 1'b1; end
      c2d_pkg::REG_KCOLS:  begin prdata = 32'(cfg_kcols);  cfg_hit = 1'b1; end
      c2d_pkg::REG_IN_CH:  begin prdata = 32'(cfg_in_ch);  cfg_hit = 1'b1; end
      c2d_pkg::REG_OUT_CH: begin prdata = 32'(cfg_out_ch); cfg_hit = 1'b1; end
      default: ;
    endcase
  end

  // Clamp each register to its usable range.
  always_comb begin
    rows_c = (cfg_rows == 11'd0) ? 11'd1 :
             (int'(cfg_rows) > c2d_pkg::MAX_IMAGE_ROWS) ? 11'(c2d_pkg::MAX_IMAGE_ROWS)
             : cfg_rows;
    cols_c = (cfg_cols == 7'd0) ? COLSW'(1) :
             (int'(cfg_cols) > MAX_COLUMNS) ? COLSW'(MAX_COLUMNS) : COLSW'(cfg_cols);
    kr_c   = (cfg_krows == 3'd0) ? KRW'(1) :
             (int'(cfg_krows) > MAX_KERNEL_ROWS) ? KRW'(MAX_KERNEL_ROWS) : KRW'(cfg_krows);
    kc_c   = (cfg_kcols == 3'd0) ? KCW'(1) :
             (int'(cfg_kcols) > MAX_KERNEL_COLS) ? KCW'(MAX_KERNEL_COLS) : KCW'(cfg_kcols);
    icn_c  = (cfg_in_ch == 5'd0) ? ICNW'(1) :
             (int'(cfg_in_ch) > MAX_IN_CHANNELS) ? ICNW'(MAX_IN_CHANNELS)
             : ICNW'(cfg_in_ch);
    ocn_c  = (cfg_out_ch == 4'd0) ? OCNW'(1) :
             (int'(cfg_out_ch) > MAX_OUT_CHANNELS) ? OCNW'(MAX_OUT_CHANNELS)
             : OCNW'(cfg_out_ch);
  end

  // A sample that completes a window starts the sequencer.
  assign fire = in_acc && is_sample &&
                (ICNW'(ch_cnt) + ICNW'(1) == icn_c) &&
                (11'(row_cnt) < rows_c) && (COLSW'(col_cnt) < cols_c) &&
                (11'(row_cnt) + 11'd1 >= 11'(kr_c)) &&
                (COLSW'(col_cnt) + COLSW'(1) >= COLSW'(kc_c));

  assign slot_sum = (SW+1)'(slot_cnt) + (SW+1)'(1);

  // Advance position counters on each sample; any register write clears them.
  always_ff @(posedge clk) begin
    if (rst || (cfg_wr && cfg_hit)) begin
      row_cnt  <= '0;
      slot_cnt <= '0;
      col_cnt  <= '0;
      ch_cnt   <= '0;
    end else if (in_acc && is_sample) begin
      if (ICNW'(ch_cnt) + ICNW'(1) >= icn_c) begin
        ch_cnt <= '0;
        if (COLSW'(col_cnt) + COLSW'(1) >= cols_c) begin
          col_cnt <= '0;
          if (11'(row_cnt) + 11'd1 >= rows_c) begin
            row_cnt  <= '0;
            slot_cnt <= '0;
          end else begin
            row_cnt  <= row_cnt + 10'd1;
            slot_cnt <= (int'(slot_cnt) == MAX_KERNEL_ROWS - 1) ? '0 : slot_cnt + SW'(1);
          end
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end else begin
        ch_cnt <= ch_cnt + ICW'(1);
      end
    end
  end

  // Line store: write the saturated sample, read one tap a cycle.
  assign wr_addr = LW'(slot_cnt) * ROW_STRIDE + LW'(col_cnt) * COL_STRIDE + LW'(ch_cnt);
  assign rd_addr = LW'(rd_slot) * ROW_STRIDE + LW'(CW'(win_col + CW'(n_idx))) * COL_STRIDE
                   + LW'(ic_idx);

  always_ff @(posedge clk) begin
    if (in_acc && is_sample) begin
      lines[wr_addr] <= c2d_pkg::sat16(in_item.value);
    end
    rd_sample <= lines[rd_addr];
  end

  // Tap index and control for the item entering the chain.
  assign ic_last = (ICNW'(ic_idx) + ICNW'(1) == icn_c);
  assign n_last  = (n_idx + KCW'(1) == kc_c);
  assign m_last  = (m_idx + KRW'(1) == kr_c);
  assign iss_tap_c = TW'(m_idx) * KROW_STRIDE + TW'(n_idx) * KCOL_STRIDE + TW'(ic_idx);
  always_comb begin
    iss_ctl_c.vld   = (state == c2d_pkg::S_RUN);
    iss_ctl_c.first = (m_idx == '0) && (n_idx == '0) && (ic_idx == '0);
    iss_ctl_c.last  = ic_last && n_last && m_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_ctl <= '0;
    end else begin
      iss_ctl <= iss_ctl_c;
    end
    iss_tap <= iss_tap_c;
  end

  // Step the window taps: input channel fastest, then column, then row.
  always_ff @(posedge clk) begin
    if (fire) begin
      m_idx   <= '0;
      n_idx   <= '0;
      ic_idx  <= '0;
      win_row <= 10'(11'(row_cnt) + 11'd1 - 11'(kr_c));
      win_col <= CW'((COLSW + 1)'(col_cnt) + (COLSW + 1)'(1) - (COLSW + 1)'(kc_c));
      rd_slot <= (slot_sum >= (SW+1)'(kr_c)) ? SW'(slot_sum - (SW+1)'(kr_c))
                 : SW'(slot_sum + (SW+1)'(MAX_KERNEL_ROWS) - (SW+1)'(kr_c));
    end else if (state == c2d_pkg::S_RUN) begin
      if (ic_last) begin
        ic_idx <= '0;
        if (n_last) begin
          n_idx <= '0;
          m_idx <= m_idx + KRW'(1);
          rd_slot <= (int'(rd_slot) == MAX_KERNEL_ROWS - 1) ? '0 : rd_slot + SW'(1);
        end else begin
          n_idx <= n_idx + KCW'(1);
        end
      end else begin
        ic_idx <= ic_idx + ICW'(1);
      end
    end
  end

  // Weight and bias writes go to the cell of their output channel.
  assign wt_ok  = (int'(in_item.tap_row) < MAX_KERNEL_ROWS) &&
                  (int'(in_item.tap_column) < MAX_KERNEL_COLS) &&
                  (int'(in_item.in_channel_sel) < MAX_IN_CHANNELS);
  assign wt_tap = TW'(in_item.tap_row) * KROW_STRIDE + TW'(in_item.tap_column) * KCOL_STRIDE
                  + TW'(in_item.in_channel_sel);

  assign ch_ctl[0]    = iss_ctl;
  assign ch_tap[0]    = iss_tap;
  assign ch_sample[0] = rd_sample;

  for (genvar k = 0; k < MAX_OUT_CHANNELS; k++) begin : g_cell
    c2d_cell #(.TAPS(TAPS), .TW(TW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_ctl    (ch_ctl[k]),
      .in_tap    (ch_tap[k]),
      .in_sample (ch_sample[k]),
      .wr_en     (in_acc && (in_item.req_type == c2d_pkg::REQ_WEIGHT) && wt_ok &&
                  (int'(in_item.out_channel_sel) == k)),
      .wr_tap    (wt_tap),
      .wr_data   (c2d_pkg::sat16(in_item.value)),
      .bias_en   (in_acc && (in_item.req_type == c2d_pkg::REQ_BIAS) &&
                  (int'(in_item.out_channel_sel) == k)),
      .bias_data (in_item.value),
      .out_ctl   (ch_ctl[k+1]),
      .out_tap   (ch_tap[k+1]),
      .out_sample(ch_sample[k+1]),
      .acc       (cell_acc[k]),
      .done      (cell_done[k])
    );
  end

  // Control state machine.
  assign oc_last  = (OCNW'(oc_idx) + OCNW'(1) == ocn_c);
  assign out_load = (state == c2d_pkg::S_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c2d_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      c2d_pkg::S_IDLE: if (fire) state_next = c2d_pkg::S_RUN;
      c2d_pkg::S_RUN:  if (ic_last && n_last && m_last) state_next = c2d_pkg::S_WAIT;
      c2d_pkg::S_WAIT: if (cell_done[MAX_OUT_CHANNELS-1]) state_next = c2d_pkg::S_EMIT;
      c2d_pkg::S_EMIT: if (out_load && oc_last) state_next = c2d_pkg::S_IDLE;
      default:         state_next = c2d_pkg::S_IDLE;
    endcase
  end

  // Output register: load one channel's sum at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == c2d_pkg::S_WAIT) begin
      oc_idx <= '0;
    end else if (out_load) begin
      oc_idx <= oc_idx + OCW'(1);
    end
    if (out_load) begin
      out_item.out_row     <= win_row;
      out_item.out_column  <= 6'(win_col);
      out_item.out_channel <= 3'(oc_idx);
      out_item.sum         <= cell_acc[oc_idx];
      out_item.last_of_run <= oc_last;
    end
  end

  `CHK_IMPLY(a_done_in_wait, cell_done[MAX_OUT_CHANNELS-1], state == c2d_pkg::S_WAIT)
  `CHK_IMPLY(a_issue_busy, iss_ctl.vld,
             state == c2d_pkg::S_RUN || state == c2d_pkg::S_WAIT)
  `CHK_NEXT(a_fire_runs, fire, state == c2d_pkg::S_RUN)

endmodule

>>> sim/tb_conv2d_multichannel_forward_unit.sv
// Self-checking regression bench for the multichannel convolution forward unit.
module tb_conv2d_multichannel_forward_unit;

  localparam int LINE_DEPTH = 5 * 64 * 16;
  localparam int WEIGHT_DEPTH = 5 * 5 * 16 * 8;
  localparam int DRAIN_CYCLES = 450;
  localparam int WATCHDOG_LIMIT = 20000;

  // Predicts convolution sums and holds the outstanding result items.
  class conv_scoreboard;
    shortint    weight_mem[WEIGHT_DEPTH];
    int         bias_mem[8];
    shortint    line_mem[LINE_DEPTH];
    int         cfg_regs[6];
    int         pos_row, pos_col, pos_ch;
    c2d_pkg::out_item_t pending_sums[$];
    int         mismatches;

    function new();
      cfg_regs = '{8, 8, 3, 3, 1, 1};
      pos_row = 0;
      pos_col = 0;
      pos_ch = 0;
      mismatches = 0;
    endfunction

    function int clampv(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function shortint clip16(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return shortint'(v);
    endfunction

    function int line_addr(int r, int c, int ch);
      return ((r % 5) * 64 + (c % 64)) * 16 + (ch % 16);
    endfunction

    function int weight_addr(int m, int n, int ic, int oc);
      return ((m * 5 + n) * 16 + ic) * 8 + oc;
    endfunction

    // Any register write restarts the image position.
    function void set_reg(c2d_pkg::reg_idx_t idx, int val);
      int masks[6];
      masks = '{'h7ff, 'h7f, 7, 7, 'h1f, 'hf};
      cfg_regs[idx] = val & masks[idx];
      pos_row = 0;
      pos_col = 0;
      pos_ch = 0;
    endfunction

    function void note_input(c2d_pkg::in_item_t it);
      int rows, cols, kr, kc, icn, ocn, i, j;
      longint acc;
      c2d_pkg::out_item_t res;
      rows = clampv(cfg_regs[c2d_pkg::REG_ROWS], 1, 1024);
      cols = clampv(cfg_regs[c2d_pkg::REG_COLS], 1, 64);
      kr = clampv(cfg_regs[c2d_pkg::REG_KROWS], 1, 5);
      kc = clampv(cfg_regs[c2d_pkg::REG_KCOLS], 1, 5);
      icn = clampv(cfg_regs[c2d_pkg::REG_IN_CH], 1, 16);
      ocn = clampv(cfg_regs[c2d_pkg::REG_OUT_CH], 1, 8);
      case (c2d_pkg::req_t'(it.req_type))
        c2d_pkg::REQ_WEIGHT: begin
          if (it.tap_row < 5 && it.tap_column < 5)
            weight_mem[weight_addr(it.tap_row, it.tap_column, it.in_channel_sel,
                                   it.out_channel_sel)] = clip16(it.value);
        end
        c2d_pkg::REQ_BIAS: begin
          bias_mem[it.out_channel_sel] = it.value;
        end
        c2d_pkg::REQ_SAMPLE: begin
          line_mem[line_addr(pos_row, pos_col, pos_ch)] = clip16(it.value);
          // Last channel of a window corner: one sum per output channel
          if (pos_ch == icn - 1 && pos_row < rows && pos_col < cols &&
              pos_row + 1 >= kr && pos_col + 1 >= kc) begin
            i = pos_row + 1 - kr;
            j = pos_col + 1 - kc;
            for (int oc = 0; oc < ocn; oc++) begin
              acc = bias_mem[oc];
              for (int m = 0; m < kr; m++)
                for (int n = 0; n < kc; n++)
                  for (int ic = 0; ic < icn; ic++)
                    acc += longint'(weight_mem[weight_addr(m, n, ic, oc)]) *
                           longint'(line_mem[line_addr(i + m, j + n, ic)]);
              res.out_row = i[9:0];
              res.out_column = j[5:0];
              res.out_channel = oc[2:0];
              res.sum = acc[47:0];
              res.last_of_run = (oc == ocn - 1);
              pending_sums.push_back(res);
            end
          end
          // Advance channel, column, row; wrap at image end
          pos_ch++;
          if (pos_ch >= icn) begin
            pos_ch = 0;
            pos_col++;
            if (pos_col >= cols) begin
              pos_col = 0;
              pos_row++;
              if (pos_row >= rows) pos_row = 0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check(c2d_pkg::out_item_t got);
      c2d_pkg::out_item_t exp_item;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row %0d col %0d ch %0d sum %0d",
                   got.out_row, got.out_column, got.out_channel, got.sum);
        return;
      end
      exp_item = pending_sums.pop_front();
      if (got.out_row !== exp_item.out_row || got.out_column !== exp_item.out_column ||
          got.out_channel !== exp_item.out_channel || got.sum !== exp_item.sum ||
          got.last_of_run !== exp_item.last_of_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp r%0d c%0d ch%0d sum %0d last %0b",
                   exp_item.out_row, exp_item.out_column, exp_item.out_channel,
                   exp_item.sum, exp_item.last_of_run);
          $display("          got r%0d c%0d ch%0d sum %0d last %0b",
                   got.out_row, got.out_column, got.out_channel, got.sum,
                   got.last_of_run);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  c2d_pkg::in_item_t  in_item;
  logic       out_valid;
  logic       out_stall;
  c2d_pkg::out_item_t out_item;
  logic       psel;
  logic       penable;
  logic       pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic       pready;

  conv_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int quiet_cycles;

  conv2d_multichannel_forward_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Track accepted items on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (out_valid && !out_stall) sb.check(out_item);
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served < hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("conv2d_multichannel_forward_unit regression: fail");
        $finish;
      end
    end
  end

  // Config write: setup then access cycle
  task automatic write_reg(c2d_pkg::reg_idx_t idx, int val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one item, with random idle cycles ahead of it
  task automatic send_item(c2d_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return {$urandom_range(1) ? 17'h1ffff : 17'h0, 15'($urandom())};
      default: return 32'($signed(16'($urandom())));
    endcase
  endfunction

  function automatic c2d_pkg::in_item_t make_item(c2d_pkg::req_t kind, int m, int n,
                                                  int ic, int oc);
    c2d_pkg::in_item_t it;
    it.req_type = kind;
    it.tap_row = m[2:0];
    it.tap_column = n[2:0];
    it.in_channel_sel = ic[3:0];
    it.out_channel_sel = oc[2:0];
    it.value = pick_value();
    return it;
  endfunction

  // Drop valid and wait until all sums are back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load weights and biases for the live kernel, then stream samples with noise
  task automatic run_image(int kr, int kc, int icn, int ocn, int samples, bit pressure);
    int roll;
    for (int m = 0; m < kr; m++)
      for (int n = 0; n < kc; n++)
        for (int ic = 0; ic < icn; ic++)
          for (int oc = 0; oc < ocn; oc++)
            send_item(make_item(c2d_pkg::REQ_WEIGHT, m, n, ic, oc));
    for (int oc = 0; oc < ocn; oc++) send_item(make_item(c2d_pkg::REQ_BIAS, 0, 0, 0, oc));
    if (pressure) hold_requests++;
    for (int s = 0; s < samples; s++) begin
      roll = $urandom_range(19);
      if (roll == 0)
        send_item(make_item(c2d_pkg::REQ_WEIGHT, $urandom_range(7, 5), $urandom_range(7),
                            $urandom_range(15), $urandom_range(7)));
      else if (roll == 1)
        send_item(make_item(c2d_pkg::REQ_NONE, $urandom_range(7), $urandom_range(7),
                            $urandom_range(15), $urandom_range(7)));
      else if (roll == 2)
        send_item(make_item(c2d_pkg::REQ_BIAS, $urandom_range(7), $urandom_range(7),
                            $urandom_range(15), $urandom_range(ocn - 1)));
      send_item(make_item(c2d_pkg::REQ_SAMPLE, $urandom_range(7), $urandom_range(7),
                          $urandom_range(15), $urandom_range(7)));
    end
    drain();
  endtask

  task automatic configure(int rows, int cols, int kr, int kc, int icn, int ocn);
    write_reg(c2d_pkg::REG_ROWS, rows);
    write_reg(c2d_pkg::REG_COLS, cols);
    write_reg(c2d_pkg::REG_KROWS, kr);
    write_reg(c2d_pkg::REG_KCOLS, kc);
    write_reg(c2d_pkg::REG_IN_CH, icn);
    write_reg(c2d_pkg::REG_OUT_CH, ocn);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    holds_served = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, no idling: 8x8 image, 3x3 kernel
    run_image(3, 3, 1, 1, 24, 1'b0);

    // Kernel taller than the image: nothing comes out
    send_idle_pct = 73;
    configure(2, 3, 3, 2, 2, 1);
    run_image(3, 2, 2, 1, 8, 1'b0);

    // Zero and oversized registers clamp; eight output channels per sample
    send_idle_pct = 0;
    stall_pct = 73;
    configure(0, 127, 0, 0, 0, 15);
    run_image(1, 1, 1, 8, 16, 1'b1);

    // Tallest image, one column, sixteen channels
    send_idle_pct = 23;
    stall_pct = 23;
    configure(2047, 1, 1, 1, 17, 1);
    run_image(1, 1, 16, 1, 24, 1'b0);

    // Largest kernel under pressure
    send_idle_pct = 0;
    stall_pct = 0;
    configure(6, 6, 6, 7, 1, 2);
    run_image(5, 5, 1, 2, 36, 1'b1);

    // Cross the position wrap into a second image
    send_idle_pct = 73;
    stall_pct = 73;
    configure(2, 3, 2, 2, 3, 3);
    run_image(2, 2, 3, 3, 24, 1'b0);

    if (sb.mismatches == 0) begin
      $display("conv2d_multichannel_forward_unit regression: pass");
    end else begin
      $display("conv2d_multichannel_forward_unit regression: fail");
    end
    $finish;
  end

endmodule
